// ===== rtl/core/rvx_pkg.sv =====
package rvx_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned IdxW  = 8;
  localparam int unsigned OpW   = 5;
  localparam int unsigned OffW  = 8;

  // Opcode numbers follow the bytecode enum order.
  localparam logic [OpW-1:0] OP_HALT  = 5'd0;
  localparam logic [OpW-1:0] OP_NOOP  = 5'd1;
  localparam logic [OpW-1:0] OP_ADD   = 5'd2;
  localparam logic [OpW-1:0] OP_SUB   = 5'd3;
  localparam logic [OpW-1:0] OP_MUL   = 5'd4;
  localparam logic [OpW-1:0] OP_DIV   = 5'd5;
  localparam logic [OpW-1:0] OP_JMP   = 5'd18;
  localparam logic [OpW-1:0] OP_JEQ   = 5'd19;
  localparam logic [OpW-1:0] OP_JLT   = 5'd20;
  localparam logic [OpW-1:0] OP_LDI   = 5'd22;
  localparam logic [OpW-1:0] OP_MOVE  = 5'd27;
  localparam logic [OpW-1:0] OP_PRINT = 5'd28;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_EXEC  = 4'b0010,
    ST_DIV   = 4'b0100,
    ST_DIVWB = 4'b1000
  } state_t;

endpackage

// ===== rtl/core/register_vm_execute_unit_core.sv =====
// Executes one decoded instruction per input beat against a REG_COUNT x 32-bit
// register file held in a synchronous memory with two read ports and one write
// port. The register-file read is issued when the beat is accepted, and the
// instruction executes and writes back in the execute state. A divide with a
// nonzero divisor then runs a radix-2 restoring divider and writes back in a
// separate writeback state. The next instruction is accepted only once the
// previous one has written back, so reads always see the latest value.
// The result register lets a finished result wait while the next beat is
// accepted; a result that cannot leave holds the unit in its final state. The
// register file reads as zero after reset through per-entry valid bits, so no
// clearing pass is needed.
module register_vm_execute_unit_core
  import rvx_pkg::*;
#(
  parameter int unsigned REG_COUNT = 256
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [OpW-1:0]         opcode,
  input  logic [IdxW-1:0]        dest_reg,
  input  logic [IdxW-1:0]        src_a,
  input  logic [IdxW-1:0]        src_b,
  input  logic signed [OffW-1:0] jump_offset,
  input  logic [DataW-1:0]       immediate,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   halted,
  output logic                   branch_taken,
  output logic signed [OffW-1:0] branch_offset,
  output logic                   print_valid,
  output logic [DataW-1:0]       print_value,
  output logic                   divide_by_zero
);

  localparam int unsigned AW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
  localparam logic [IdxW:0] RegLimit = (IdxW+1)'(REG_COUNT);
  localparam logic [4:0] DivLast = 5'd31;

  state_t state, state_next;

  logic [DataW-1:0] regs [REG_COUNT];
  logic [REG_COUNT-1:0] vld;

  logic                   in_accept;
  logic [OpW-1:0]         op_q;
  logic [IdxW-1:0]        dest_q;
  logic signed [OffW-1:0] off_q;
  logic [DataW-1:0]       imm_q;
  logic [DataW-1:0]       rdata_a, rdata_b;
  logic                   rok_a, rok_b;

  logic [DataW-1:0] va, vb;
  logic [2*DataW-1:0] prod;

  logic [DataW-1:0] quo, rem, dvs;
  logic [4:0]       div_cnt;
  logic [DataW:0]   rem_sh, diff;

  logic             out_free;
  logic             wr_en;
  logic [DataW-1:0] wr_data;
  logic             dest_ok;

  logic                   r_halted, r_taken, r_pvalid, r_dz;
  logic signed [OffW-1:0] r_off;
  logic [DataW-1:0]       r_pvalue;
  logic                   emit;

  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign dest_ok   = ({1'b0, dest_q} < RegLimit);

  assign va   = rok_a ? rdata_a : '0;
  assign vb   = rok_b ? rdata_b : '0;
  assign prod = va * vb;

  assign rem_sh = {rem, quo[DataW-1]};
  assign diff   = rem_sh - {1'b0, dvs};

  // Register file: reads issued on the accepted beat, one write port.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      rdata_a <= regs[src_a[AW-1:0]];
      rdata_b <= regs[src_b[AW-1:0]];
    end
    if (wr_en) begin
      regs[dest_q[AW-1:0]] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      rok_a <= 1'b0;
      rok_b <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[dest_q[AW-1:0]] <= 1'b1;
      end
      if (in_accept) begin
        rok_a <= ({1'b0, src_a} < RegLimit) && vld[src_a[AW-1:0]];
        rok_b <= ({1'b0, src_b} < RegLimit) && vld[src_b[AW-1:0]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_q   <= opcode;
      dest_q <= dest_reg;
      off_q  <= jump_offset;
      imm_q  <= immediate;
    end
  end

  // Execute stage decode, writeback and result formation.
  always_comb begin
    state_next = state;
    wr_en      = 1'b0;
    wr_data    = '0;
    emit       = 1'b0;
    r_halted   = 1'b0;
    r_taken    = 1'b0;
    r_off      = '0;
    r_pvalid   = 1'b0;
    r_pvalue   = '0;
    r_dz       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_accept) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (op_q)
          OP_NOOP: ;
          OP_ADD:  wr_data = va + vb;
          OP_SUB:  wr_data = va - vb;
          OP_MUL:  wr_data = prod[DataW-1:0];
          OP_DIV: begin
            wr_data = '1;
            r_dz    = (vb == '0);
          end
          OP_JMP:   r_taken = 1'b1;
          OP_JEQ:   r_taken = (va == vb);
          OP_JLT:   r_taken = (va < vb);
          OP_LDI:   wr_data = imm_q;
          OP_MOVE:  wr_data = va;
          OP_PRINT: begin
            r_pvalid = 1'b1;
            r_pvalue = va;
          end
          default:  r_halted = 1'b1;
        endcase
        r_off = r_taken ? off_q : '0;
        if (op_q == OP_DIV && vb != '0) begin
          state_next = ST_DIV;
        end else if (out_free) begin
          emit       = 1'b1;
          state_next = ST_IDLE;
          wr_en      = dest_ok && (op_q == OP_ADD || op_q == OP_SUB ||
                       op_q == OP_MUL || op_q == OP_DIV || op_q == OP_LDI ||
                       op_q == OP_MOVE);
        end
      end
      ST_DIV: begin
        if (div_cnt == DivLast) begin
          state_next = ST_DIVWB;
        end
      end
      ST_DIVWB: begin
        wr_data = quo;
        if (out_free) begin
          emit       = 1'b1;
          wr_en      = dest_ok;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Restoring divider, one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (state == ST_EXEC) begin
      div_cnt <= '0;
    end else if (state == ST_DIV) begin
      div_cnt <= div_cnt + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EXEC) begin
      quo <= va;
      dvs <= vb;
      rem <= '0;
    end else if (state == ST_DIV) begin
      if (!diff[DataW]) begin
        rem <= diff[DataW-1:0];
        quo <= {quo[DataW-2:0], 1'b1};
      end else begin
        rem <= rem_sh[DataW-1:0];
        quo <= {quo[DataW-2:0], 1'b0};
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      halted         <= r_halted;
      branch_taken   <= r_taken;
      branch_offset  <= r_off;
      print_valid    <= r_pvalid;
      print_value    <= r_pvalue;
      divide_by_zero <= r_dz;
    end
  end

  a_accept_to_exec: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> state == ST_EXEC)
    else $error("accepted beat did not enter execute");

  a_no_write_on_accept: assert property (@(posedge clk) disable iff (rst)
    !(wr_en && in_accept))
    else $error("register write overlaps a new read");

  a_div_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV && div_cnt == DivLast) |=> state == ST_DIVWB)
    else $error("divider did not finish after 32 steps");

  a_offset_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !branch_taken) |-> branch_offset == '0)
    else $error("offset reported for a branch not taken");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    (out_valid && divide_by_zero) |-> (!halted && !print_valid && !branch_taken))
    else $error("divide-by-zero beat carries other flags");

endmodule
